// ===== rtl/lcfr_pkg.sv =====
// Types and constants shared by the frame receiver modules.
// No dependencies.
package lcfr_pkg;

   localparam logic [7:0] CHECK_BASE     = 8'hFF;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd3;
   localparam logic [7:0] TIMEOUT_RESET  = 8'd10;

   localparam logic KIND_BYTE       = 1'b0;
   localparam logic KIND_TICK       = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic store;
      logic tick;
      logic clear;
      logic scan_start;
      logic scan_step;
      logic emit_start;
      logic load_out;
      logic load_fail;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_discard;
      logic frame_ready;
      logic scan_done;
      logic sum_match;
      logic out_last;
      logic fill_empty;
   } dp_sts_type;

endpackage

// ===== rtl/lcfr_datapath.sv =====
// Datapath: frame store, fill and idle counters, checksum scan and result register.
// Depends on lcfr_pkg; driven by lcfr_controller.
module lcfr_datapath #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_tdata,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  lcfr_pkg::dp_cmd_type cmd,
   output lcfr_pkg::dp_sts_type sts,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);
   import lcfr_pkg::*;

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int AW = $clog2(BUFFER_BYTES);

   logic [7:0]    store_mem [BUFFER_BYTES];

   logic [7:0]    timeout_ff;
   logic [7:0]    idle_ff, idle_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] data_idx_ff;
   logic          vld_ff, vld_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    rdata_ff;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_status_ff, out_status_in;
   logic          out_last_ff, out_last_in;

   logic [8:0]    flen;
   logic [8:0]    flen_m1;
   logic [8:0]    fill_w;
   logic [8:0]    idx_w;
   logic [8:0]    data_idx_w;
   logic [7:0]    idle_dec;
   logic          store_ok;

   assign flen       = {1'b0, len_ff} + FRAME_OVERHEAD;
   assign flen_m1    = flen - 9'd1;
   assign fill_w     = 9'(fill_ff);
   assign idx_w      = 9'(idx_ff);
   assign data_idx_w = 9'(data_idx_ff);
   assign idle_dec   = idle_ff - {7'd0, (idle_ff != 8'd0)};
   assign store_ok   = cmd.store && (fill_ff < CW'(BUFFER_BYTES));

   always_comb begin
      fill_in       = fill_ff;
      idle_in       = idle_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      vld_in        = vld_ff;
      sum_in        = sum_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (store_ok) begin
         fill_in = fill_ff + CW'(1);
         idle_in = timeout_ff;
         if (fill_ff == '0) begin
            len_in = req_tdata;
         end
      end
      if (cmd.tick) begin
         idle_in = idle_dec;
      end
      if (cmd.clear) begin
         fill_in = '0;
      end
      if (cmd.scan_start) begin
         idx_in = '0;
         vld_in = 1'b0;
         sum_in = CHECK_BASE;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + CW'(1);
         vld_in = 1'b1;
         if (vld_ff && (data_idx_w != flen_m1)) begin
            sum_in = sum_ff - rdata_ff;
         end
      end
      if (cmd.emit_start) begin
         idx_in = '0;
      end
      if (cmd.load_out) begin
         out_byte_in   = rdata_ff;
         out_status_in = STATUS_OK;
         out_last_in   = (idx_w == flen_m1);
         idx_in        = idx_ff + CW'(1);
      end
      if (cmd.load_fail) begin
         out_byte_in   = 8'd0;
         out_status_in = STATUS_MISMATCH;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         idle_ff    <= 8'd0;
         fill_ff    <= '0;
         vld_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         idle_ff <= idle_in;
         fill_ff <= fill_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      data_idx_ff   <= idx_ff;
      sum_ff        <= sum_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_ok) begin
         store_mem[fill_ff[AW-1:0]] <= req_tdata;
      end
      if (idx_ff < CW'(BUFFER_BYTES)) begin
         rdata_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   assign sts.tick_discard = (fill_ff != '0) && (idle_dec == 8'd0);
   assign sts.frame_ready  = (fill_ff != '0) && (fill_w >= flen);
   assign sts.scan_done    = vld_ff && (data_idx_w == flen_m1);
   assign sts.sum_match    = (rdata_ff == sum_ff);
   assign sts.out_last     = out_last_ff;
   assign sts.fill_empty   = (fill_ff == '0);

   assign rsp_tdata = out_byte_ff;
   assign rsp_tuser = out_status_ff;
   assign rsp_tlast = out_last_ff;

endmodule

// ===== rtl/lcfr_controller.sv =====
// Controller: sequences byte/tick handling, checksum scan and frame emission.
// Depends on lcfr_pkg; drives lcfr_datapath.
module lcfr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  lcfr_pkg::dp_sts_type sts,
   output lcfr_pkg::dp_cmd_type cmd
);
   import lcfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PRIME,
      ST_LOAD,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == KIND_BYTE) begin
                  cmd.store = 1'b1;
               end else begin
                  cmd.tick = 1'b1;
                  if (sts.tick_discard) begin
                     cmd.clear = 1'b1;
                  end else if (sts.frame_ready) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               if (sts.sum_match) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_PRIME;
               end else begin
                  cmd.load_fail = 1'b1;
                  valid_in      = 1'b1;
                  state_in      = ST_HOLD;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_PRIME: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_out = 1'b1;
            valid_in     = 1'b1;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               if (sts.out_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            valid_in = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/length_checksum_frame_receiver.sv =====
// Top level of the length/checksum frame receiver: controller plus datapath.
// Depends on lcfr_pkg, lcfr_controller, lcfr_datapath.
//
//   channel  dir  tdata            tuser    tlast
//   req_     in   byte_value[7:0]  kind     -
//   rsp_     out  frame_byte[7:0]  status   last
//   csr_     in   idle_timeout_ticks[7:0] via csr_wr_en / csr_wr_data
//
// A byte beat, or a tick that finds no complete frame, is handled in idle.
// A tick on a complete frame scans len+3 stored bytes at one read per cycle,
// then emits each byte (or one mismatch beat), holding on any rsp stall.
// No request is taken while a frame is checked or emitted.
// Reset is synchronous; the frame store is not cleared.
module length_checksum_frame_receiver #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic       rsp_tuser,   // [0] status
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import lcfr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   lcfr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lcfr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // one item in flight: no request taken while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while result pending");

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_MISMATCH)) |-> (rsp_tlast && (rsp_tdata == 8'd0)))
      else $error("mismatch beat malformed");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (sts.fill_empty && req_tready))
      else $error("buffer not cleared after final beat");

   a_scan_needs_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> (req_tvalid && (req_tuser == KIND_TICK) && sts.frame_ready))
      else $error("scan started without a tick on a complete frame");

endmodule
